FILE: design/assert_macros.svh
// Assertion macros shared by the eviction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swlru: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swlru: next-cycle check failed");

`endif

FILE: design/swlru_pkg.sv
package swlru_pkg;

  // Width of the slot number on the ports.
  localparam int ID_W = 6;

  typedef enum logic [1:0] {
    OP_TOUCH = 2'd0,
    OP_STORE = 2'd1,
    OP_DROP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Flag part of one result.
  typedef struct packed {
    logic is_eviction;
    logic status;
    logic last;
  } res_ctl_t;

  // Field write enables of the link memory.
  typedef struct packed {
    logic prev;
    logic next;
  } link_we_t;

endpackage

FILE: design/size_weighted_lru_eviction.sv
// Each operation runs from its input transfer to its final result in the output register;
// a store first emits an eviction result, not marked last, for each entry it evicts.
// Throughput: one operation at a time; the next input transfer is taken the cycle after
// the final result enters the output register. Output stalls hold an operation up.
// Reset (synchronous, active low) empties the list, clears the total, sets capacity to all
// ones and then sweeps the slot memory with input stalled.
`include "assert_macros.svh"

module size_weighted_lru_eviction #(
  parameter int ENTRIES   = 64,
  parameter int SIZE_BITS = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [swlru_pkg::ID_W-1:0]  in_entry_id,
  input  logic [SIZE_BITS-1:0]        in_entry_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_eviction,
  output logic [swlru_pkg::ID_W-1:0]  out_evicted_id,
  output logic                        out_status,
  output logic [SIZE_BITS-1:0]        out_total_size,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [SIZE_BITS-1:0]        cfg_wdata
);
  import swlru_pkg::*;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int LW     = $clog2(ENTRIES + 1);

  // The sequencer owns the list ends, the running total and the capacity.
  // Slot state lives in two memories: the links (with separate write enables
  // for the previous and next fields) and the occupancy flag with the size.
  logic                 res_push;
  res_ctl_t             res_ctl;
  logic [ID_W-1:0]      res_id;
  logic [SIZE_BITS-1:0] res_total;
  logic                 res_ready;

  logic [SLOT_W-1:0]    mem_raddr;
  link_we_t             lk_we;
  logic [SLOT_W-1:0]    lk_waddr;
  logic [LW-1:0]        lk_wprev;
  logic [LW-1:0]        lk_wnext;
  logic [LW-1:0]        lk_rprev;
  logic [LW-1:0]        lk_rnext;
  logic                 inf_we;
  logic [SLOT_W-1:0]    inf_waddr;
  logic                 inf_wvalid;
  logic [SIZE_BITS-1:0] inf_wsize;
  logic                 inf_rvalid;
  logic [SIZE_BITS-1:0] inf_rsize;

  logic                 out_valid_r, out_valid_nxt;
  res_ctl_t             out_ctl_r;
  logic [ID_W-1:0]      out_id_r;
  logic [SIZE_BITS-1:0] out_total_r;

  swlru_ctrl #(
    .ENTRIES   (ENTRIES),
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_opcode     (in_opcode),
    .in_entry_id   (in_entry_id),
    .in_entry_size (in_entry_size),
    .in_stall      (in_stall),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .res_push      (res_push),
    .res_ctl       (res_ctl),
    .res_id        (res_id),
    .res_total     (res_total),
    .res_ready     (res_ready),
    .mem_raddr     (mem_raddr),
    .lk_we         (lk_we),
    .lk_waddr      (lk_waddr),
    .lk_wprev      (lk_wprev),
    .lk_wnext      (lk_wnext),
    .lk_rprev      (lk_rprev),
    .lk_rnext      (lk_rnext),
    .inf_we        (inf_we),
    .inf_waddr     (inf_waddr),
    .inf_wvalid    (inf_wvalid),
    .inf_wsize     (inf_wsize),
    .inf_rvalid    (inf_rvalid),
    .inf_rsize     (inf_rsize)
  );

  swlru_link_mem #(
    .ENTRIES (ENTRIES)
  ) u_link_mem (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wprev (lk_wprev),
    .wnext (lk_wnext),
    .raddr (mem_raddr),
    .rprev (lk_rprev),
    .rnext (lk_rnext)
  );

  swlru_info_mem #(
    .ENTRIES   (ENTRIES),
    .SIZE_BITS (SIZE_BITS)
  ) u_info_mem (
    .clk    (clk),
    .we     (inf_we),
    .waddr  (inf_waddr),
    .wvalid (inf_wvalid),
    .wsize  (inf_wsize),
    .raddr  (mem_raddr),
    .rvalid (inf_rvalid),
    .rsize  (inf_rsize)
  );

  // Output register. It takes a new result whenever it is empty or its
  // current result is being transferred in the same cycle, so a waiting
  // final result never holds up the next input transfer.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_push && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push && res_ready) begin
      out_ctl_r   <= res_ctl;
      out_id_r    <= res_id;
      out_total_r <= res_total;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_eviction = out_ctl_r.is_eviction;
  assign out_status      = out_ctl_r.status;
  assign out_last        = out_ctl_r.last;
  assign out_evicted_id  = out_id_r;
  assign out_total_size  = out_total_r;

  // A result handed over by the sequencer shows up on the output next cycle.
  `SWL_ASSERT_NEXT(a_result_loaded, clk, rst_n, res_push && res_ready, out_valid)

endmodule

FILE: design/swlru_link_mem.sv
module swlru_link_mem #(
  parameter int ENTRIES = 64
) (
  input  logic                           clk,
  input  swlru_pkg::link_we_t            we,
  input  logic [$clog2(ENTRIES)-1:0]     waddr,
  input  logic [$clog2(ENTRIES+1)-1:0]   wprev,
  input  logic [$clog2(ENTRIES+1)-1:0]   wnext,
  input  logic [$clog2(ENTRIES)-1:0]     raddr,
  output logic [$clog2(ENTRIES+1)-1:0]   rprev,
  output logic [$clog2(ENTRIES+1)-1:0]   rnext
);
  import swlru_pkg::*;

  localparam int LW = $clog2(ENTRIES + 1);

  // Each word holds the previous link in the upper half, the next link below.
  logic [2*LW-1:0] mem [ENTRIES];
  logic [2*LW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we.prev) begin
      mem[waddr][2*LW-1:LW] <= wprev;
    end
    if (we.next) begin
      mem[waddr][LW-1:0] <= wnext;
    end
    rdata_r <= mem[raddr];
  end

  assign rprev = rdata_r[2*LW-1:LW];
  assign rnext = rdata_r[LW-1:0];

endmodule

FILE: design/swlru_info_mem.sv
module swlru_info_mem #(
  parameter int ENTRIES   = 64,
  parameter int SIZE_BITS = 40
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic                       wvalid,
  input  logic [SIZE_BITS-1:0]       wsize,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output logic                       rvalid,
  output logic [SIZE_BITS-1:0]       rsize
);

  // Occupancy flag on top of the entry size.
  logic [SIZE_BITS:0] mem [ENTRIES];
  logic [SIZE_BITS:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalid, wsize};
    end
    rdata_r <= mem[raddr];
  end

  assign rvalid = rdata_r[SIZE_BITS];
  assign rsize  = rdata_r[SIZE_BITS-1:0];

endmodule

FILE: design/swlru_ctrl.sv
`include "assert_macros.svh"

module swlru_ctrl #(
  parameter int ENTRIES   = 64,
  parameter int SIZE_BITS = 40
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [1:0]                       in_opcode,
  input  logic [swlru_pkg::ID_W-1:0]       in_entry_id,
  input  logic [SIZE_BITS-1:0]             in_entry_size,
  output logic                             in_stall,
  input  logic                             cfg_we,
  input  logic [SIZE_BITS-1:0]             cfg_wdata,
  output logic                             res_push,
  output swlru_pkg::res_ctl_t              res_ctl,
  output logic [swlru_pkg::ID_W-1:0]       res_id,
  output logic [SIZE_BITS-1:0]             res_total,
  input  logic                             res_ready,
  output logic [$clog2(ENTRIES)-1:0]       mem_raddr,
  output swlru_pkg::link_we_t              lk_we,
  output logic [$clog2(ENTRIES)-1:0]       lk_waddr,
  output logic [$clog2(ENTRIES+1)-1:0]     lk_wprev,
  output logic [$clog2(ENTRIES+1)-1:0]     lk_wnext,
  input  logic [$clog2(ENTRIES+1)-1:0]     lk_rprev,
  input  logic [$clog2(ENTRIES+1)-1:0]     lk_rnext,
  output logic                             inf_we,
  output logic [$clog2(ENTRIES)-1:0]       inf_waddr,
  output logic                             inf_wvalid,
  output logic [SIZE_BITS-1:0]             inf_wsize,
  input  logic                             inf_rvalid,
  input  logic [SIZE_BITS-1:0]             inf_rsize
);
  import swlru_pkg::*;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int LW     = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0]     HEAD      = LW'(ENTRIES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_LOOK    = 11'b00000000100,
    S_UNL_P   = 11'b00000001000,
    S_UNL_N   = 11'b00000010000,
    S_EVAL    = 11'b00000100000,
    S_EV_LOOK = 11'b00001000000,
    S_EMIT    = 11'b00010000000,
    S_LNK_S   = 11'b00100000000,
    S_LNK_F   = 11'b01000000000,
    S_FINAL   = 11'b10000000000
  } state_t;

  state_t                st_r, st_nxt;
  logic [SLOT_W-1:0]     clr_r, clr_nxt;
  logic                  ev_r, ev_nxt;
  logic [LW-1:0]         mr_r, mr_nxt;
  logic [LW-1:0]         lr_r, lr_nxt;
  logic [SIZE_BITS-1:0]  total_r, total_nxt;
  logic [SIZE_BITS-1:0]  cap_r, cap_nxt;
  op_t                   op_r, op_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [SIZE_BITS-1:0]  size_r, size_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]         p_r, p_nxt;
  logic [LW-1:0]         n_r, n_nxt;
  logic [SIZE_BITS-1:0]  csize_r, csize_nxt;
  logic                  status_r, status_nxt;

  logic                  id_ok;
  logic [SLOT_W-1:0]     in_slot;
  logic [SIZE_BITS-1:0]  cap_room;

  assign id_ok    = (32'(in_entry_id) < 32'(ENTRIES));
  assign in_slot  = SLOT_W'(in_entry_id);
  assign cap_room = cap_r - size_r;
  assign in_stall = (st_r != S_IDLE);
  assign res_total = total_r;

  always_comb begin
    st_nxt     = st_r;
    clr_nxt    = clr_r;
    ev_nxt     = ev_r;
    mr_nxt     = mr_r;
    lr_nxt     = lr_r;
    total_nxt  = total_r;
    cap_nxt    = cfg_we ? cfg_wdata : cap_r;
    op_nxt     = op_r;
    slot_nxt   = slot_r;
    size_nxt   = size_r;
    cur_nxt    = cur_r;
    p_nxt      = p_r;
    n_nxt      = n_r;
    csize_nxt  = csize_r;
    status_nxt = status_r;

    mem_raddr  = slot_r;
    lk_we      = '0;
    lk_waddr   = slot_r;
    lk_wprev   = HEAD;
    lk_wnext   = mr_r;
    inf_we     = 1'b0;
    inf_waddr  = slot_r;
    inf_wvalid = 1'b0;
    inf_wsize  = size_r;
    res_push   = 1'b0;
    res_ctl    = '0;
    res_id     = '0;

    unique case (st_r)
      S_CLEAR: begin
        inf_we    = 1'b1;
        inf_waddr = clr_r;
        inf_wsize = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = in_slot;
        if (in_valid) begin
          op_nxt     = op_t'(in_opcode);
          slot_nxt   = in_slot;
          size_nxt   = in_entry_size;
          status_nxt = 1'b0;
          ev_nxt     = 1'b0;
          if (!id_ok || op_t'(in_opcode) == OP_NONE) begin
            st_nxt = S_FINAL;
          end else begin
            st_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        cur_nxt   = slot_r;
        p_nxt     = lk_rprev;
        n_nxt     = lk_rnext;
        csize_nxt = inf_rsize;
        unique case (op_r)
          OP_STORE: st_nxt = inf_rvalid ? S_UNL_P : S_EVAL;
          default:  st_nxt = inf_rvalid ? S_UNL_P : S_FINAL;
        endcase
      end
      S_UNL_P: begin
        if (p_r == HEAD) begin
          mr_nxt = n_r;
        end else begin
          lk_we.next = 1'b1;
          lk_waddr   = p_r[SLOT_W-1:0];
          lk_wnext   = n_r;
        end
        st_nxt = S_UNL_N;
      end
      S_UNL_N: begin
        if (n_r == HEAD) begin
          lr_nxt = p_r;
        end else begin
          lk_we.prev = 1'b1;
          lk_waddr   = n_r[SLOT_W-1:0];
          lk_wprev   = p_r;
        end
        // Everything but a touch takes the entry out of the cache.
        if (ev_r || op_r != OP_TOUCH) begin
          inf_we    = 1'b1;
          inf_waddr = cur_r;
          inf_wsize = csize_r;
          total_nxt = (total_r >= csize_r) ? total_r - csize_r : '0;
        end
        if (ev_r) begin
          st_nxt = S_EMIT;
        end else begin
          unique case (op_r)
            OP_TOUCH: st_nxt = S_LNK_S;
            OP_STORE: st_nxt = S_EVAL;
            default:  st_nxt = S_FINAL;
          endcase
        end
      end
      S_EVAL: begin
        mem_raddr = lr_r[SLOT_W-1:0];
        if (size_r > cap_r) begin
          status_nxt = 1'b1;
          st_nxt     = S_FINAL;
        end else if (total_r > cap_room && lr_r != HEAD) begin
          cur_nxt = lr_r[SLOT_W-1:0];
          st_nxt  = S_EV_LOOK;
        end else begin
          st_nxt = S_LNK_S;
        end
      end
      S_EV_LOOK: begin
        p_nxt     = lk_rprev;
        n_nxt     = lk_rnext;
        csize_nxt = inf_rsize;
        ev_nxt    = 1'b1;
        st_nxt    = S_UNL_P;
      end
      S_EMIT: begin
        res_push            = 1'b1;
        res_ctl.is_eviction = 1'b1;
        res_id              = ID_W'(cur_r);
        if (res_ready) begin
          ev_nxt = 1'b0;
          st_nxt = S_EVAL;
        end
      end
      S_LNK_S: begin
        lk_we.prev = 1'b1;
        lk_we.next = 1'b1;
        lk_waddr   = slot_r;
        lk_wprev   = HEAD;
        lk_wnext   = mr_r;
        if (op_r == OP_STORE) begin
          inf_we     = 1'b1;
          inf_waddr  = slot_r;
          inf_wvalid = 1'b1;
          inf_wsize  = size_r;
          total_nxt  = total_r + size_r;
        end
        if (mr_r == HEAD) begin
          lr_nxt = LW'(slot_r);
          mr_nxt = LW'(slot_r);
          st_nxt = S_FINAL;
        end else begin
          st_nxt = S_LNK_F;
        end
      end
      S_LNK_F: begin
        lk_we.prev = 1'b1;
        lk_waddr   = mr_r[SLOT_W-1:0];
        lk_wprev   = LW'(slot_r);
        mr_nxt     = LW'(slot_r);
        st_nxt     = S_FINAL;
      end
      S_FINAL: begin
        res_push       = 1'b1;
        res_ctl.status = status_r;
        res_ctl.last   = 1'b1;
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      clr_r   <= '0;
      ev_r    <= 1'b0;
      mr_r    <= HEAD;
      lr_r    <= HEAD;
      total_r <= '0;
      cap_r   <= '1;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      ev_r    <= ev_nxt;
      mr_r    <= mr_nxt;
      lr_r    <= lr_nxt;
      total_r <= total_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    slot_r   <= slot_nxt;
    size_r   <= size_nxt;
    cur_r    <= cur_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    csize_r  <= csize_nxt;
    status_r <= status_nxt;
  end

  // Between operations the list is either empty at both ends or at neither.
  `SWL_ASSERT_IMPL(a_heads_agree, clk, rst_n, st_r == S_IDLE, (mr_r == HEAD) == (lr_r == HEAD))
  // The least recent entry picked for eviction must be occupied.
  `SWL_ASSERT_IMPL(a_victim_valid, clk, rst_n, st_r == S_EV_LOOK, inf_rvalid)
  // No memory write may collide with the read issued for a new item.
  `SWL_ASSERT_IMPL(a_idle_no_write, clk, rst_n, st_r == S_IDLE, !inf_we && !lk_we.prev && !lk_we.next)

endmodule
